// ===== rtl/core/sma_pkg.sv =====
// Shared types and constants for the stack machine ALU.
package sma_pkg;

  localparam int DATA_W    = 32;
  localparam int DIV_CNT_W = $clog2(DATA_W);

  typedef enum logic [3:0] {
    OP_PUSH = 4'd0,
    OP_POP  = 4'd1,
    OP_ADD  = 4'd2,
    OP_SUB  = 4'd3,
    OP_MUL  = 4'd4,
    OP_DIV  = 4'd5,
    OP_GT   = 4'd6,
    OP_LT   = 4'd7,
    OP_EQ   = 4'd8,
    OP_NE   = 4'd9,
    OP_GE   = 4'd10,
    OP_LE   = 4'd11
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_DIVZERO   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP,
    S_RD_S,
    S_EXEC,
    S_DIV,
    S_FINISH
  } state_t;

endpackage

// ===== rtl/core/sma_mem.sv =====
// Stack storage: one write port, one registered read port.
module sma_mem import sma_pkg::*; #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sma_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module sma_div import sma_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DATA_W-1:0]    dvd;
  logic [DATA_W-1:0]    dvs;
  logic [DATA_W-1:0]    rem;
  logic                 neg;
  logic [DATA_W-1:0]    rem_sh;
  logic [DATA_W:0]      diff;

  // remainder stays below the divisor magnitude (at most 2^31), so the shift loses nothing
  assign rem_sh   = {rem[DATA_W-2:0], dvd[DATA_W-1]};
  assign diff     = {1'b0, rem_sh} - {1'b0, dvs};
  assign quotient = neg ? (DATA_W'(0) - dvd) : dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
      dvs <= divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
      rem <= '0;
      neg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy) begin
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        dvd <= {dvd[DATA_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        dvd <= {dvd[DATA_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/core/stack_machine_alu.sv =====
// Operand-stack execution unit: top level with sequencer, stack RAM and divider.
//
// Input channel (in_valid/in_ready): req_type opcode and push_value. One word
// per item; the unit works on one item at a time, in_ready is high while idle.
// Output channel (out_valid/out_ready): result_value, status, depth, one word
// per item, held in an output register so a stalled receiver does not block
// acceptance of the next item; the sequencer only waits at its final step
// while that register is still full.
// Push and unused opcodes go from decode to finish; pop adds a pop step and
// binary ops add read and execute steps, divide then waits on the bit-serial
// divider. Binary ops read top and second entries one after the other over
// the single read port of the stack RAM, whose read data is registered.
// Reset clears the stack pointer (empty stack), the sequencer and the output
// valid; RAM contents are not cleared and entries above the pointer are never
// used.
module stack_machine_alu import sma_pkg::*; #(
  parameter int STACK_DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [3:0]        req_type,
  input  logic [DATA_W-1:0] push_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] result_value,
  output logic [1:0]        status,
  output logic [7:0]        depth
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  state_t            state, state_next;
  logic [3:0]        op;
  logic [DATA_W-1:0] val;
  logic [SPW-1:0]    sp, sp_next;
  logic [DATA_W-1:0] t_reg, t_next;
  logic [DATA_W-1:0] res, res_next;
  status_t           stat, stat_next;

  logic [SPW-1:0]    sp_m1, sp_m2;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;
  logic              div_start, div_done;
  logic [DATA_W-1:0] div_quot;
  logic [DATA_W-1:0] alu_res;
  logic              accept, out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign sp_m1    = sp - SPW'(1);
  assign sp_m2    = sp - SPW'(2);

  sma_mem #(.DEPTH(STACK_DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sma_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mem_rdata),
    .divisor  (t_reg),
    .done     (div_done),
    .quotient (div_quot)
  );

  // second entry arrives on mem_rdata in S_EXEC, top entry sits in t_reg
  always_comb begin
    unique case (op)
      OP_ADD:  alu_res = mem_rdata + t_reg;
      OP_SUB:  alu_res = mem_rdata - t_reg;
      OP_MUL:  alu_res = mem_rdata * t_reg;
      OP_GT:   alu_res = DATA_W'($signed(mem_rdata) >  $signed(t_reg));
      OP_LT:   alu_res = DATA_W'($signed(mem_rdata) <  $signed(t_reg));
      OP_EQ:   alu_res = DATA_W'(mem_rdata == t_reg);
      OP_NE:   alu_res = DATA_W'(mem_rdata != t_reg);
      OP_GE:   alu_res = DATA_W'($signed(mem_rdata) >= $signed(t_reg));
      OP_LE:   alu_res = DATA_W'($signed(mem_rdata) <= $signed(t_reg));
      default: alu_res = '0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_DECODE;
      end
      S_DECODE: begin
        priority if (op == OP_PUSH) state_next = S_FINISH;
        else if (op == OP_POP) state_next = (sp == '0) ? S_FINISH : S_POP;
        else if (op <= OP_LE) state_next = (sp < SPW'(2)) ? S_FINISH : S_RD_S;
        else state_next = S_FINISH;
      end
      S_POP:  state_next = S_FINISH;
      S_RD_S: state_next = S_EXEC;
      S_EXEC: begin
        if (op == OP_DIV && t_reg != '0) state_next = S_DIV;
        else state_next = S_FINISH;
      end
      S_DIV: begin
        if (div_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    sp_next   = sp;
    t_next    = t_reg;
    res_next  = res;
    stat_next = stat;
    mem_we    = 1'b0;
    mem_waddr = sp_m2[AW-1:0];
    mem_wdata = alu_res;
    mem_raddr = sp_m1[AW-1:0];
    div_start = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_next  = '0;
          stat_next = ST_OK;
        end
      end
      S_DECODE: begin
        priority if (op == OP_PUSH) begin
          if (sp == SPW'(STACK_DEPTH)) begin
            stat_next = ST_OVERFLOW;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = sp[AW-1:0];
            mem_wdata = val;
            sp_next   = sp + SPW'(1);
          end
        end else if (op == OP_POP) begin
          if (sp == '0) begin
            stat_next = ST_UNDERFLOW;
            res_next  = '1;
          end
        end else if (op <= OP_LE) begin
          if (sp < SPW'(2)) stat_next = ST_UNDERFLOW;
        end else begin
          stat_next = ST_OK;
        end
      end
      S_POP: begin
        res_next = mem_rdata;
        sp_next  = sp_m1;
      end
      S_RD_S: begin
        t_next    = mem_rdata;
        mem_raddr = sp_m2[AW-1:0];
      end
      S_EXEC: begin
        if (op == OP_DIV) begin
          if (t_reg == '0) stat_next = ST_DIVZERO;
          else div_start = 1'b1;
        end else begin
          mem_we   = 1'b1;
          res_next = alu_res;
          sp_next  = sp_m1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          mem_we    = 1'b1;
          mem_wdata = div_quot;
          res_next  = div_quot;
          sp_next   = sp_m1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      sp    <= sp_next;
      if (state == S_FINISH && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    t_reg <= t_next;
    res   <= res_next;
    stat  <= stat_next;
    if (accept) begin
      op  <= req_type;
      val <= push_value;
    end
    if (state == S_FINISH && out_free) begin
      result_value <= res;
      status       <= stat;
      depth        <= 8'(sp);
    end
  end

endmodule
